/* rtl/rnm_pkg.sv */
// Shared types, constants and helpers for the reactive navigation mode controller.
`default_nettype none

package rnm_pkg;

  // Field widths
  localparam int RANGE_BITS  = 16;
  localparam int SPEED_W     = 15;
  localparam int TURN_W      = 15;
  localparam int MODE_W      = 3;
  localparam int SCAN_LEN_W  = 11;
  localparam int EDGE_W      = 8;
  localparam int BAND_W      = 12;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;

  // Default maximum scan length in samples
  localparam int MAX_SAMPLES_DEF = 1024;

  // Depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADVANCE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TURN    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WALL    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SPIRAL  = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LENGTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_SKIP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLLISION_DIST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WALL_DIST      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WALL_BAND      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_MEAN_DIST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPEED   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIRAL_SPEED   = 3'd7;

  // Register reset values
  localparam logic [SCAN_LEN_W-1:0] RST_SCAN_LENGTH    = 11'd1024;
  localparam logic [EDGE_W-1:0]     RST_EDGE_SKIP      = 8'd150;
  localparam logic [RANGE_BITS-1:0] RST_COLLISION_DIST = 16'd1050;
  localparam logic [RANGE_BITS-1:0] RST_WALL_DIST      = 16'd1000;
  localparam logic [BAND_W-1:0]     RST_WALL_BAND      = 12'd50;
  localparam logic [RANGE_BITS-1:0] RST_OPEN_MEAN_DIST = 16'd3200;
  localparam logic [SPEED_W-1:0]    RST_CRUISE_SPEED   = 15'd12000;
  localparam logic [SPEED_W-1:0]    RST_SPIRAL_SPEED   = 15'd4000;

  // Command constants
  localparam logic [SPEED_W-1:0]        SLOW_SPEED        = 15'd1000;
  localparam logic [SPEED_W:0]          SPIRAL_SPEED_STEP = 16'd12;
  localparam logic signed [TURN_W-1:0]  FULL_TURN         = 15'sd10000;
  localparam logic signed [TURN_W-1:0]  SPIRAL_START_TURN = 15'sd5000;
  localparam logic signed [TURN_W-1:0]  WALL_TURN         = 15'sd2000;
  localparam logic signed [TURN_W-1:0]  SPIRAL_TURN_STEP  = 15'sd5;
  localparam logic signed [TURN_W-1:0]  TURN_ZERO         = 15'sd0;

  // Per-scan classification handed from front to back
  typedef struct packed {
    logic coin;
    logic collide;
    logic clear_ahead;
    logic right_gt_left;
    logic right_near;
    logic right_far;
    logic open_space;
  } scan_class_t;

  // floor(n/3) by reciprocal multiply, exact for any 16-bit n
  function automatic logic [15:0] div3(input logic [15:0] n);
    logic [32:0] p;
    p = {17'b0, n} * 33'h0AAAB;
    return p[32:17];
  endfunction

endpackage

`default_nettype wire

/* rtl/rnm_front.sv */
// Front part: takes range samples, keeps sector minima and sums, classifies each scan.
`default_nettype none

module rnm_front #(
  parameter int MAX_SAMPLES = rnm_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [rnm_pkg::RANGE_BITS-1:0]     distance,
  input  wire logic                               last_sample,
  input  wire logic                               coin,
  input  wire logic [rnm_pkg::SCAN_LEN_W-1:0]     scan_length,
  input  wire logic [rnm_pkg::EDGE_W-1:0]         edge_skip,
  input  wire logic [rnm_pkg::RANGE_BITS-1:0]     collision_dist,
  input  wire logic [rnm_pkg::RANGE_BITS-1:0]     wall_dist,
  input  wire logic [rnm_pkg::BAND_W-1:0]         wall_band,
  input  wire logic [rnm_pkg::RANGE_BITS-1:0]     open_mean_dist,
  output logic                                    push_valid,
  input  wire logic                               push_ready,
  output rnm_pkg::scan_class_t                    push_data
);

  localparam int IDX_W = $clog2(MAX_SAMPLES + 1);
  localparam int LEN_W = (IDX_W > rnm_pkg::SCAN_LEN_W) ? IDX_W : rnm_pkg::SCAN_LEN_W;
  localparam int BW    = LEN_W + 2;
  localparam int SUM_W = rnm_pkg::RANGE_BITS + IDX_W;
  localparam int RW    = rnm_pkg::RANGE_BITS + 2;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SAMPLES);
  localparam logic [LEN_W-1:0] ONE_LEN = LEN_W'(1);
  localparam logic signed [BW-1:0] ONE_S = BW'(1);

  // Sector bounds derived from configuration
  logic [LEN_W-1:0]        len_ext;
  logic [LEN_W-1:0]        len_clamp;
  logic [15:0]             third_w;
  logic signed [BW-1:0]    len_s;
  logic signed [BW-1:0]    third_s;
  logic signed [BW-1:0]    edge_s;
  logic [IDX_W-1:0]        len_r;
  logic signed [BW-1:0]    centre_lo;
  logic signed [BW-1:0]    centre_hi;
  logic signed [BW-1:0]    right_lo;
  logic signed [BW-1:0]    right_hi;
  logic signed [BW-1:0]    left_lo;
  logic signed [BW-1:0]    left_hi;

  // Sample register
  logic                          s1_valid;
  logic [rnm_pkg::RANGE_BITS-1:0] s1_dist;
  logic                          s1_last;
  logic                          s1_coin;
  logic                          s1_fire;

  // Scan accumulators
  logic [IDX_W-1:0]               idx;
  logic [rnm_pkg::RANGE_BITS-1:0] centre_min;
  logic [rnm_pkg::RANGE_BITS-1:0] right_min;
  logic [rnm_pkg::RANGE_BITS-1:0] left_min;
  logic [SUM_W-1:0]               range_sum;
  logic [SUM_W-1:0]               open_acc;

  logic [rnm_pkg::RANGE_BITS-1:0] centre_min_next;
  logic [rnm_pkg::RANGE_BITS-1:0] right_min_next;
  logic [rnm_pkg::RANGE_BITS-1:0] left_min_next;
  logic [SUM_W-1:0]               range_sum_next;
  logic [SUM_W-1:0]               open_acc_next;
  logic [IDX_W-1:0]               idx_next;

  logic                  in_range;
  logic signed [BW-1:0]  i_s;
  logic                  in_centre;
  logic                  in_right;
  logic                  in_left;
  logic signed [RW-1:0]  right_s;
  logic signed [RW-1:0]  wall_lo_s;
  logic signed [RW-1:0]  wall_hi_s;

  // Clamp the scan length and split it into thirds
  always_comb begin
    len_ext = {{(LEN_W - rnm_pkg::SCAN_LEN_W){1'b0}}, scan_length};
    if (len_ext == '0) begin
      len_clamp = ONE_LEN;
    end else if (len_ext > MAX_LEN) begin
      len_clamp = MAX_LEN;
    end else begin
      len_clamp = len_ext;
    end
    third_w = rnm_pkg::div3(16'(len_clamp));
    len_s   = $signed({2'b00, len_clamp});
    third_s = $signed({{(BW - IDX_W){1'b0}}, third_w[IDX_W-1:0]});
    edge_s  = $signed({{(BW - rnm_pkg::EDGE_W){1'b0}}, edge_skip});
  end

  always_ff @(posedge clk) begin
    len_r     <= len_clamp[IDX_W-1:0];
    centre_lo <= third_s;
    centre_hi <= len_s - third_s - ONE_S;
    right_lo  <= len_s - third_s;
    right_hi  <= len_s - edge_s;
    left_lo   <= edge_s;
    left_hi   <= third_s - ONE_S;
  end

  // Input handshake: the sample register frees when its transfer completes
  assign s1_fire    = s1_valid && (!s1_last || push_ready);
  assign in_ready   = !s1_valid || s1_fire;
  assign push_valid = s1_valid && s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_dist <= distance;
      s1_last <= last_sample;
      s1_coin <= coin;
    end
  end

  // Sector membership and running minima
  always_comb begin
    in_range  = idx < len_r;
    i_s       = $signed({{(BW - IDX_W){1'b0}}, idx});
    in_centre = (i_s >= centre_lo) && (i_s < centre_hi);
    in_right  = (i_s >= right_lo) && (i_s < right_hi);
    in_left   = (i_s >= left_lo) && (i_s < left_hi);

    centre_min_next = centre_min;
    right_min_next  = right_min;
    left_min_next   = left_min;
    range_sum_next  = range_sum;
    open_acc_next   = open_acc;
    idx_next        = idx;
    if (in_range) begin
      if (in_centre && s1_dist < centre_min) centre_min_next = s1_dist;
      if (in_right && s1_dist < right_min) right_min_next = s1_dist;
      if (in_left && s1_dist < left_min) left_min_next = s1_dist;
      range_sum_next = range_sum + SUM_W'(s1_dist);
      open_acc_next  = open_acc + SUM_W'(open_mean_dist);
      idx_next       = idx + IDX_W'(1);
    end
  end

  // Classify the finished scan
  always_comb begin
    right_s   = $signed({2'b00, right_min_next});
    wall_lo_s = $signed({2'b00, wall_dist}) -
                $signed({{(RW - rnm_pkg::BAND_W){1'b0}}, wall_band});
    wall_hi_s = $signed({2'b00, wall_dist}) +
                $signed({{(RW - rnm_pkg::BAND_W){1'b0}}, wall_band});
    push_data.coin          = s1_coin;
    push_data.collide       = centre_min_next < collision_dist;
    push_data.clear_ahead   = centre_min_next > collision_dist;
    push_data.right_gt_left = right_min_next > left_min_next;
    push_data.right_near    = right_s < wall_lo_s;
    push_data.right_far     = right_s >= wall_hi_s;
    push_data.open_space    = range_sum_next > open_acc_next;
  end

  // Accumulators restart after the last sample of a scan
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      centre_min <= '1;
      right_min  <= '1;
      left_min   <= '1;
      range_sum  <= '0;
      open_acc   <= '0;
    end else if (s1_fire) begin
      if (s1_last) begin
        idx        <= '0;
        centre_min <= '1;
        right_min  <= '1;
        left_min   <= '1;
        range_sum  <= '0;
        open_acc   <= '0;
      end else begin
        idx        <= idx_next;
        centre_min <= centre_min_next;
        right_min  <= right_min_next;
        left_min   <= left_min_next;
        range_sum  <= range_sum_next;
        open_acc   <= open_acc_next;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/rnm_fifo.sv */
// Short queue of scan classifications between the front and back parts.
`default_nettype none

module rnm_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push_valid,
  output logic                       push_ready,
  input  wire rnm_pkg::scan_class_t  push_data,
  output logic                       pop_valid,
  input  wire logic                  pop_ready,
  output rnm_pkg::scan_class_t       pop_data
);

  localparam int PTR_W = (rnm_pkg::Q_DEPTH > 1) ? $clog2(rnm_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(rnm_pkg::Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(rnm_pkg::Q_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(rnm_pkg::Q_DEPTH);

  rnm_pkg::scan_class_t entries [rnm_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != FULL_CNT;
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/rnm_back.sv */
// Back part: five-mode controller that turns each scan class into the held command.
`default_nettype none

module rnm_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              pop_valid,
  output logic                                   pop_ready,
  input  wire rnm_pkg::scan_class_t              pop_data,
  input  wire logic [rnm_pkg::SPEED_W-1:0]       cruise_speed,
  input  wire logic [rnm_pkg::SPEED_W-1:0]       spiral_speed,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [rnm_pkg::MODE_W-1:0]             next_mode,
  output logic [rnm_pkg::SPEED_W-1:0]            forward_speed,
  output logic signed [rnm_pkg::TURN_W-1:0]      turn_rate
);

  logic [rnm_pkg::MODE_W-1:0]         mode;
  logic [rnm_pkg::SPEED_W-1:0]        held_speed;
  logic signed [rnm_pkg::TURN_W-1:0]  held_turn;

  logic [rnm_pkg::MODE_W-1:0]         mode_next;
  logic [rnm_pkg::SPEED_W-1:0]        held_speed_next;
  logic signed [rnm_pkg::TURN_W-1:0]  held_turn_next;

  logic [rnm_pkg::SPEED_W:0]          sp_inc;
  logic [rnm_pkg::SPEED_W-1:0]        sp_ramp;
  logic signed [rnm_pkg::TURN_W-1:0]  tr_ramp;
  logic signed [rnm_pkg::TURN_W-1:0]  avoid_turn;
  logic                               do_pop;

  // Output register frees when empty or being taken
  assign pop_ready = !out_valid || out_ready;
  assign do_pop    = pop_valid && pop_ready;

  // Held command is shown directly on the result ports
  assign next_mode     = mode;
  assign forward_speed = held_speed;
  assign turn_rate     = held_turn;

  // Spiral ramps and collision escape direction
  always_comb begin
    sp_inc  = {1'b0, held_speed} + rnm_pkg::SPIRAL_SPEED_STEP;
    if (held_speed < spiral_speed) begin
      sp_ramp = sp_inc[rnm_pkg::SPEED_W] ? '1 : sp_inc[rnm_pkg::SPEED_W-1:0];
    end else begin
      sp_ramp = held_speed;
    end
    tr_ramp    = (held_turn > rnm_pkg::TURN_ZERO) ?
                 held_turn - rnm_pkg::SPIRAL_TURN_STEP : held_turn;
    avoid_turn = pop_data.right_gt_left ? -rnm_pkg::FULL_TURN : rnm_pkg::FULL_TURN;
  end

  // Mode transitions
  always_comb begin
    mode_next       = mode;
    held_speed_next = held_speed;
    held_turn_next  = held_turn;
    case (mode)
      rnm_pkg::MODE_ADVANCE: begin
        if (pop_data.collide) begin
          mode_next       = rnm_pkg::MODE_TURN;
          held_speed_next = rnm_pkg::SLOW_SPEED;
          held_turn_next  = avoid_turn;
        end else if (pop_data.open_space) begin
          mode_next       = rnm_pkg::MODE_SPIRAL;
          held_speed_next = rnm_pkg::SLOW_SPEED;
          held_turn_next  = rnm_pkg::SPIRAL_START_TURN;
        end else begin
          mode_next       = rnm_pkg::MODE_ADVANCE;
          held_speed_next = cruise_speed;
          held_turn_next  = rnm_pkg::TURN_ZERO;
        end
      end
      rnm_pkg::MODE_TURN: begin
        if (pop_data.clear_ahead) begin
          mode_next       = pop_data.coin ? rnm_pkg::MODE_WALL : rnm_pkg::MODE_ADVANCE;
          held_speed_next = cruise_speed;
          held_turn_next  = rnm_pkg::TURN_ZERO;
        end
      end
      rnm_pkg::MODE_WALL: begin
        if (pop_data.collide) begin
          mode_next       = rnm_pkg::MODE_TURN;
          held_speed_next = rnm_pkg::SLOW_SPEED;
          held_turn_next  = avoid_turn;
        end else if (pop_data.right_near) begin
          mode_next       = rnm_pkg::MODE_WALL;
          held_speed_next = cruise_speed;
          held_turn_next  = -rnm_pkg::WALL_TURN;
        end else if (pop_data.right_far) begin
          mode_next       = rnm_pkg::MODE_WALL;
          held_speed_next = cruise_speed;
          held_turn_next  = rnm_pkg::WALL_TURN;
        end
      end
      rnm_pkg::MODE_SPIRAL: begin
        if (pop_data.collide) begin
          mode_next       = rnm_pkg::MODE_TURN;
          held_speed_next = rnm_pkg::SLOW_SPEED;
          held_turn_next  = avoid_turn;
        end else begin
          mode_next       = rnm_pkg::MODE_SPIRAL;
          held_speed_next = sp_ramp;
          held_turn_next  = tr_ramp;
        end
      end
      default: begin
        // idle and unused codes start advancing
        mode_next       = rnm_pkg::MODE_ADVANCE;
        held_speed_next = cruise_speed;
        held_turn_next  = rnm_pkg::TURN_ZERO;
      end
    endcase
  end

  // Held command and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= rnm_pkg::MODE_IDLE;
      held_speed <= '0;
      held_turn  <= '0;
      out_valid  <= 1'b0;
    end else if (do_pop) begin
      mode       <= mode_next;
      held_speed <= held_speed_next;
      held_turn  <= held_turn_next;
      out_valid  <= 1'b1;
    end else if (out_ready) begin
      out_valid  <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/reactive_navigation_mode_fsm_core.sv */
// Top level of the reactive navigation mode controller: configuration and part wiring.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one laser range sample per transfer,
//   with last_sample marking the end of a scan and coin the random bit.
//   Output channel (out_valid/out_ready) carries one command per scan: next_mode,
//   forward_speed and turn_rate. Samples that are not last produce no result.
//   Throughput: one sample per cycle unless a last sample waits on a full queue.
//   The front updates sector minima and the range sum per sample; scan classes
//   queue in a two-entry buffer. A finished scan passes the sample register, the
//   queue and the output register. When the receiver stalls, the command holds in
//   the output register, the queue absorbs up to two more finished scans, and
//   samples keep flowing until a third last sample finds the queue full.
//   Reset (rst, synchronous) restores register defaults, mode idle, zero command
//   and empty accumulators; no warm-up pass is needed.
//   Configuration writes (cfg_write/cfg_index/cfg_data) land at the write edge;
//   the sector bounds follow in the next cycle. Writes must be made while no
//   scan is in flight; the block itself does not enforce this.
`default_nettype none

module reactive_navigation_mode_fsm_core #(
  parameter int MAX_SAMPLES = rnm_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [rnm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rnm_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [rnm_pkg::RANGE_BITS-1:0]   distance,
  input  wire logic                             last_sample,
  input  wire logic                             coin,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [rnm_pkg::MODE_W-1:0]            next_mode,
  output logic [rnm_pkg::SPEED_W-1:0]           forward_speed,
  output logic signed [rnm_pkg::TURN_W-1:0]     turn_rate
);

  logic [rnm_pkg::SCAN_LEN_W-1:0] scan_length;
  logic [rnm_pkg::EDGE_W-1:0]     edge_skip;
  logic [rnm_pkg::RANGE_BITS-1:0] collision_dist;
  logic [rnm_pkg::RANGE_BITS-1:0] wall_dist;
  logic [rnm_pkg::BAND_W-1:0]     wall_band;
  logic [rnm_pkg::RANGE_BITS-1:0] open_mean_dist;
  logic [rnm_pkg::SPEED_W-1:0]    cruise_speed;
  logic [rnm_pkg::SPEED_W-1:0]    spiral_speed;

  logic                 push_valid;
  logic                 push_ready;
  rnm_pkg::scan_class_t push_data;
  logic                 pop_valid;
  logic                 pop_ready;
  rnm_pkg::scan_class_t pop_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_length    <= rnm_pkg::RST_SCAN_LENGTH;
      edge_skip      <= rnm_pkg::RST_EDGE_SKIP;
      collision_dist <= rnm_pkg::RST_COLLISION_DIST;
      wall_dist      <= rnm_pkg::RST_WALL_DIST;
      wall_band      <= rnm_pkg::RST_WALL_BAND;
      open_mean_dist <= rnm_pkg::RST_OPEN_MEAN_DIST;
      cruise_speed   <= rnm_pkg::RST_CRUISE_SPEED;
      spiral_speed   <= rnm_pkg::RST_SPIRAL_SPEED;
    end else if (cfg_write) begin
      case (cfg_index)
        rnm_pkg::CFG_SCAN_LENGTH:    scan_length    <= cfg_data[rnm_pkg::SCAN_LEN_W-1:0];
        rnm_pkg::CFG_EDGE_SKIP:      edge_skip      <= cfg_data[rnm_pkg::EDGE_W-1:0];
        rnm_pkg::CFG_COLLISION_DIST: collision_dist <= cfg_data[rnm_pkg::RANGE_BITS-1:0];
        rnm_pkg::CFG_WALL_DIST:      wall_dist      <= cfg_data[rnm_pkg::RANGE_BITS-1:0];
        rnm_pkg::CFG_WALL_BAND:      wall_band      <= cfg_data[rnm_pkg::BAND_W-1:0];
        rnm_pkg::CFG_OPEN_MEAN_DIST: open_mean_dist <= cfg_data[rnm_pkg::RANGE_BITS-1:0];
        rnm_pkg::CFG_CRUISE_SPEED:   cruise_speed   <= cfg_data[rnm_pkg::SPEED_W-1:0];
        rnm_pkg::CFG_SPIRAL_SPEED:   spiral_speed   <= cfg_data[rnm_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample intake and scan classification
  rnm_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .distance       (distance),
    .last_sample    (last_sample),
    .coin           (coin),
    .scan_length    (scan_length),
    .edge_skip      (edge_skip),
    .collision_dist (collision_dist),
    .wall_dist      (wall_dist),
    .wall_band      (wall_band),
    .open_mean_dist (open_mean_dist),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  // Decoupling queue
  rnm_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Mode controller and result register
  rnm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .cruise_speed  (cruise_speed),
    .spiral_speed  (spiral_speed),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .next_mode     (next_mode),
    .forward_speed (forward_speed),
    .turn_rate     (turn_rate)
  );

endmodule

`default_nettype wire
